FILE: src/cfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_pkg
// shared types, constants and crc helpers for the command frame codec
// ----------------------------------------------------------------------------
package cfc_pkg;

   localparam int FRAME_BYTES_DEFAULT = 7;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_INDEX_BITS      = 2;

   // item opcodes
   localparam logic OP_SEND = 1'b0;
   localparam logic OP_RECV = 1'b1;

   // result kinds
   localparam logic KIND_TX  = 1'b0;
   localparam logic KIND_RSP = 1'b1;

   // check status
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END  = 2'd1;

   localparam logic [7:0]  HEAD_RESET   = 8'h68;
   localparam logic [7:0]  END_RESET    = 8'h16;
   localparam logic [7:0]  START_MARK   = 8'h68;
   localparam logic [7:0]  MISMATCH_CMD = 8'hFF;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam int          CRC_SPAN     = 4;

   typedef struct packed {
      logic       opcode;
      logic [7:0] command_code;
      logic [7:0] data_first;
      logic [7:0] data_second;
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       rx_status;
      logic [7:0] rx_command;
      logic [7:0] rx_data_first;
      logic [7:0] rx_data_second;
   } rsp_type;

   // classified work entry between front and back
   typedef struct packed {
      logic       op;
      logic [7:0] cmd;
      logic [7:0] d1;
      logic [7:0] d2;
      logic [7:0] rx_byte;
      logic       rx_last;
   } work_type;

   typedef struct packed {
      logic [7:0] head_byte;
      logic [7:0] end_byte;
   } cfg_type;

   // reflected table entry, eight shift steps on one byte
   function automatic logic [15:0] crc_table(input logic [7:0] idx);
      logic [15:0] r;
      r = {8'h00, idx};
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      return {8'h00, crc[15:8]} ^ crc_table(crc[7:0] ^ data);
   endfunction

endpackage

FILE: src/cfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_front
// input stage: takes request beats, classifies them and hands them to the queue
// ----------------------------------------------------------------------------
module cfc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfc_pkg::req_type  req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output cfc_pkg::work_type push_entry
);
   import cfc_pkg::*;

   logic     hold_ff, hold_in;
   work_type entry_ff, entry_in;
   logic     accept;
   logic     take;

   assign take      = hold_ff && push_ready;
   assign req_stall = hold_ff && !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      entry_in = entry_ff;
      hold_in  = hold_ff;
      if (accept) begin
         hold_in = 1'b1;
         if (req_data.opcode == OP_SEND) begin
            entry_in = '{op: OP_SEND, cmd: req_data.command_code,
                         d1: req_data.data_first, d2: req_data.data_second,
                         rx_byte: 8'h00, rx_last: 1'b0};
         end else begin
            entry_in = '{op: OP_RECV, cmd: 8'h00, d1: 8'h00, d2: 8'h00,
                         rx_byte: req_data.rx_byte, rx_last: req_data.rx_last};
         end
      end else if (take) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      entry_ff <= entry_in;
   end

   assign push_valid = hold_ff;
   assign push_entry = entry_ff;

endmodule

FILE: src/cfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_queue
// short work queue between the front and back parts
// ----------------------------------------------------------------------------
module cfc_queue #(
   parameter int DEPTH = cfc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cfc_pkg::work_type push_entry,
   output logic              pop_valid,
   input  logic              pop_take,
   output cfc_pkg::work_type pop_entry
);
   import cfc_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   work_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_take && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/cfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_back
// execution part: frame build with crc, receive buffer and frame check
// ----------------------------------------------------------------------------
module cfc_back #(
   parameter int FRAME_BYTES = cfc_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cfc_pkg::cfg_type  cfg,
   input  logic              work_valid,
   output logic              work_take,
   input  cfc_pkg::work_type work_entry,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfc_pkg::rsp_type  rsp_data
);
   import cfc_pkg::*;

   localparam int AW    = $clog2(FRAME_BYTES);
   localparam int CNT_W = $clog2(FRAME_BYTES + 1);
   localparam int POS_W = $clog2(FRAME_BYTES + 6);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TX_CRC,
      ST_TX_EMIT,
      ST_RX_READ,
      ST_RX_RESULT
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       step_ff, step_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       d1_ff, d1_in;
   logic [7:0]       d2_ff, d2_in;
   logic [15:0]      got_ff, got_in;
   logic [AW-1:0]    emit_ff, emit_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]    start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [7:0]       rx_mem [FRAME_BYTES];
   logic [7:0]       rd_data_ff;
   logic             rd_ok_ff;
   logic [POS_W-1:0] rd_pos;
   logic             mem_we;

   logic             out_free;
   logic             out_load;
   logic [7:0]       crc_byte;
   logic [7:0]       rd_byte;
   logic [7:0]       tx_sel;
   logic [15:0]      want;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_pos   = POS_W'(start_ff) + POS_W'(step_ff);
   assign rd_byte  = rd_ok_ff ? rd_data_ff : 8'h00;
   // wire order: low byte of the register goes out first
   assign want     = {crc_ff[7:0], crc_ff[15:8]};
   assign work_take = (state_ff == ST_IDLE) && work_valid;
   assign mem_we    = work_take && (work_entry.op == OP_RECV)
                      && (count_ff < CNT_W'(FRAME_BYTES));

   always_comb begin
      unique case (step_ff)
         3'd0:    crc_byte = cfg.head_byte;
         3'd1:    crc_byte = cmd_ff;
         3'd2:    crc_byte = d1_ff;
         default: crc_byte = d2_ff;
      endcase
   end

   always_comb begin
      if (emit_ff == AW'(0)) begin
         tx_sel = cfg.head_byte;
      end else if (emit_ff == AW'(1)) begin
         tx_sel = cmd_ff;
      end else if (emit_ff == AW'(2)) begin
         tx_sel = d1_ff;
      end else if (emit_ff == AW'(3)) begin
         tx_sel = d2_ff;
      end else if (emit_ff == AW'(4)) begin
         tx_sel = crc_ff[7:0];
      end else if (emit_ff == AW'(5)) begin
         tx_sel = crc_ff[15:8];
      end else if (emit_ff == AW'(6)) begin
         tx_sel = cfg.end_byte;
      end else begin
         tx_sel = 8'h00;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      crc_in       = crc_ff;
      cmd_in       = cmd_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      got_in       = got_ff;
      emit_in      = emit_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      rsp_data_in  = rsp_data_ff;
      out_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (work_valid) begin
               crc_in  = CRC_INIT;
               step_in = '0;
               if (work_entry.op == OP_SEND) begin
                  cmd_in   = work_entry.cmd;
                  d1_in    = work_entry.d1;
                  d2_in    = work_entry.d2;
                  state_in = ST_TX_CRC;
               end else begin
                  if (mem_we) begin
                     if (work_entry.rx_byte == START_MARK) begin
                        start_in = count_ff[AW-1:0];
                     end
                     count_in = count_ff + 1'b1;
                  end
                  if (work_entry.rx_last) begin
                     state_in = ST_RX_READ;
                  end
               end
            end
         end
         ST_TX_CRC: begin
            crc_in  = crc_step(crc_ff, crc_byte);
            step_in = step_ff + 1'b1;
            if (step_ff == 3'(CRC_SPAN - 1)) begin
               emit_in  = '0;
               state_in = ST_TX_EMIT;
            end
         end
         ST_TX_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_data_in = '{result_kind: KIND_TX, tx_byte: tx_sel,
                               tx_last: (emit_ff == AW'(FRAME_BYTES - 1)),
                               rx_status: 1'b0, rx_command: 8'h00,
                               rx_data_first: 8'h00, rx_data_second: 8'h00};
               if (emit_ff == AW'(FRAME_BYTES - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         ST_RX_READ: begin
            // read data of the previous step arrives now
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               3'd0: begin
               end
               3'd1: crc_in = crc_step(crc_ff, rd_byte);
               3'd2: begin
                  crc_in = crc_step(crc_ff, rd_byte);
                  cmd_in = rd_byte;
               end
               3'd3: begin
                  crc_in = crc_step(crc_ff, rd_byte);
                  d1_in  = rd_byte;
               end
               3'd4: begin
                  crc_in = crc_step(crc_ff, rd_byte);
                  d2_in  = rd_byte;
               end
               3'd5: got_in[15:8] = rd_byte;
               default: begin
                  got_in[7:0] = rd_byte;
                  state_in    = ST_RX_RESULT;
               end
            endcase
         end
         ST_RX_RESULT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (got_ff == want) begin
                  rsp_data_in = '{result_kind: KIND_RSP, tx_byte: 8'h00, tx_last: 1'b0,
                                  rx_status: STATUS_OK, rx_command: cmd_ff,
                                  rx_data_first: d1_ff, rx_data_second: d2_ff};
               end else begin
                  rsp_data_in = '{result_kind: KIND_RSP, tx_byte: 8'h00, tx_last: 1'b0,
                                  rx_status: STATUS_BAD, rx_command: MISMATCH_CMD,
                                  rx_data_first: 8'h00, rx_data_second: 8'h00};
               end
               count_in = '0;
               start_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      crc_ff      <= crc_in;
      cmd_ff      <= cmd_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      got_ff      <= got_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // receive buffer, positions at or past the fill count read as zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rx_mem[count_ff[AW-1:0]] <= work_entry.rx_byte;
      end
      rd_data_ff <= rx_mem[rd_pos[AW-1:0]];
      rd_ok_ff   <= (rd_pos < POS_W'(count_ff));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FRAME_BYTES))
      else $error("receive fill count past buffer size");

   a_start_filled: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(start_ff) < count_ff) || (start_ff == '0))
      else $error("frame start points at unfilled position");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");

   a_clear_after_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RX_RESULT && out_free) |=> (count_ff == '0 && state_ff == ST_IDLE))
      else $error("receive state not cleared after frame check");

endmodule

FILE: src/crc16_command_frame_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_command_frame_codec
// builds and checks short command frames protected by crc-16/modbus
// ----------------------------------------------------------------------------
// usage:
//  req_* carries one beat per item: opcode 0 sends a frame (command and two
//  data bytes), opcode 1 delivers one received byte, rx_last closes the frame.
//  rsp_* returns result beats: a send gives FRAME_BYTES transmit beats (head,
//  cmd, data, crc in wire order, end byte, zero pad), a closed receive frame
//  gives one decoded response beat.
//  csr_* writes head_byte (index 0) and end_byte (index 1); always ready.
// timing:
//  a request passes an input stage and a queue to the back part.
//  send: a dispatch step, then crc over head, cmd and data (one byte a cycle
//  through the crc table), then one transmit beat per cycle while not stalled.
//  receive byte: taken in the idle state; the last byte adds buffer reads
//  (one read port, one byte a cycle) and a result step for the response.
// reset: head/end bytes return to 0x68/0x16, receive buffer is empty.
// stall: rsp_stall holds the output register; the queue then fills and
//  req_stall rises once the input stage cannot drain.
// ----------------------------------------------------------------------------
module crc16_command_frame_codec #(
   parameter int FRAME_BYTES = cfc_pkg::FRAME_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = cfc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cfc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cfc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [7:0]                         csr_wdata
);
   import cfc_pkg::*;

   // configuration registers
   logic [7:0] head_ff, head_in;
   logic [7:0] end_ff, end_in;
   cfg_type    cfg;

   // front to queue
   logic       push_valid;
   logic       push_ready;
   work_type   push_entry;

   // queue to back
   logic       work_valid;
   logic       work_take;
   work_type   work_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      head_in = head_ff;
      end_in  = end_ff;
      if (csr_valid && csr_ready) begin
         // writes to unknown indexes are ignored
         if (csr_index == CSR_HEAD) begin
            head_in = csr_wdata;
         end else if (csr_index == CSR_END) begin
            end_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         end_ff  <= END_RESET;
      end else begin
         head_ff <= head_in;
         end_ff  <= end_in;
      end
   end

   assign cfg = '{head_byte: head_ff, end_byte: end_ff};

   // accept and classify request beats
   cfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decouples intake from frame execution
   cfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (work_valid),
      .pop_take   (work_take),
      .pop_entry  (work_entry)
   );

   // frame build, receive buffer and check
   cfc_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .work_valid (work_valid),
      .work_take  (work_take),
      .work_entry (work_entry),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: bench/crc16_command_frame_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_command_frame_codec_tb
// self-checking bench for the crc-16/modbus command frame codec
// ----------------------------------------------------------------------------
// The bench keeps a cycle-free model of the codec: its framing registers, the
// receive buffer, the fill count and the frame start. Every request beat that
// the block accepts is run through that model, and the beats it predicts are
// queued. The response beats are compared field by field, in order, against
// that queue.
//
// The stimulus runs as a series of test tasks:
//  - directed sends and receive frames
//  - framing register extremes
//  - random traffic under several register settings
//  - a long response hold-off that backs the block up into its input
// Both sides idle at random, apart from one stretch that runs flat out.
// ----------------------------------------------------------------------------
module crc16_command_frame_codec_tb;
   import cfc_pkg::*;

   localparam int FRAME_LEN     = FRAME_BYTES_DEFAULT;
   localparam int SETTLE_CYCLES = 40;      // covers the longest back-end pass
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;

   typedef logic [7:0] byte_q_t [$];

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_HEAD;
   logic [7:0]                csr_wdata = '0;

   // model state of the codec
   logic [7:0] head_cfg;
   logic [7:0] tail_cfg;
   logic [7:0] rx_shadow [FRAME_LEN];
   int         rx_fill;
   int         rx_origin;

   rsp_type pending_beats [$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   int      hold_left   = 0;
   bit      req_gaps    = 1'b1;
   bit      rsp_gaps    = 1'b1;

   crc16_command_frame_codec dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // model
   // ---------------------------------------------------------------------

   // crc-16/modbus over four bytes, returned with the first wire byte on top
   function automatic logic [15:0] crc16_wire(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3);
      logic [7:0]  msg [4];
      logic [15:0] r;
      msg[0] = b0;
      msg[1] = b1;
      msg[2] = b2;
      msg[3] = b3;
      r = CRC_INIT;
      for (int i = 0; i < 4; i++) begin
         r = r ^ {8'h00, msg[i]};
         for (int b = 0; b < 8; b++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         end
      end
      return {r[7:0], r[15:8]};
   endfunction

   // positions never filled or past the buffer read as zero
   function automatic logic [7:0] shadow_at(input int pos);
      return (pos < FRAME_LEN) ? rx_shadow[pos] : 8'h00;
   endfunction

   function automatic void clear_rx_shadow();
      for (int k = 0; k < FRAME_LEN; k++) begin
         rx_shadow[k] = 8'h00;
      end
      rx_fill   = 0;
      rx_origin = 0;
   endfunction

   // advance the model by one accepted request beat, queue what it yields
   function automatic void codec_predict(input req_type it);
      rsp_type     beat;
      logic [7:0]  frame [FRAME_LEN];
      logic [15:0] want;
      logic [15:0] got;
      logic [7:0]  hdr [4];
      if (it.opcode == OP_SEND) begin
         for (int k = 0; k < FRAME_LEN; k++) begin
            frame[k] = 8'h00;
         end
         frame[0] = head_cfg;
         frame[1] = it.command_code;
         frame[2] = it.data_first;
         frame[3] = it.data_second;
         want = crc16_wire(frame[0], frame[1], frame[2], frame[3]);
         frame[4] = want[15:8];
         frame[5] = want[7:0];
         frame[6] = tail_cfg;
         for (int k = 0; k < FRAME_LEN; k++) begin
            beat             = '0;
            beat.result_kind = KIND_TX;
            beat.tx_byte     = frame[k];
            beat.tx_last     = (k == FRAME_LEN - 1);
            pending_beats.push_back(beat);
         end
      end else begin
         // bytes past a full buffer are neither stored nor searched
         if (rx_fill < FRAME_LEN) begin
            rx_shadow[rx_fill] = it.rx_byte;
            if (it.rx_byte == START_MARK) begin
               rx_origin = rx_fill;
            end
            rx_fill++;
         end
         if (it.rx_last) begin
            for (int k = 0; k < 4; k++) begin
               hdr[k] = shadow_at(rx_origin + k);
            end
            want = crc16_wire(hdr[0], hdr[1], hdr[2], hdr[3]);
            got  = {shadow_at(rx_origin + 4), shadow_at(rx_origin + 5)};
            beat             = '0;
            beat.result_kind = KIND_RSP;
            if (got == want) begin
               beat.rx_status      = STATUS_OK;
               beat.rx_command     = hdr[1];
               beat.rx_data_first  = hdr[2];
               beat.rx_data_second = hdr[3];
            end else begin
               beat.rx_status  = STATUS_BAD;
               beat.rx_command = MISMATCH_CMD;
            end
            pending_beats.push_back(beat);
            clear_rx_shadow();
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // response side: stall pattern and checking
   // ---------------------------------------------------------------------

   // a long hold-off, when requested, wins over the random stall
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_gaps && ($urandom_range(99) < 10);
      end
   end

   function automatic void check_field(input string fname, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: rsp field %s mismatch, expected %h actual %h",
                  $time, fname, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_beats.pop_front();
            check_field("result_kind", 8'(want.result_kind), 8'(rsp_data.result_kind));
            check_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
            check_field("tx_last", 8'(want.tx_last), 8'(rsp_data.tx_last));
            check_field("rx_status", 8'(want.rx_status), 8'(rsp_data.rx_status));
            check_field("rx_command", want.rx_command, rsp_data.rx_command);
            check_field("rx_data_first", want.rx_data_first, rsp_data.rx_data_first);
            check_field("rx_data_second", want.rx_data_second, rsp_data.rx_data_second);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // offer one beat and hold it until accepted; valid stays up afterwards so
   // the next beat can follow back to back
   task automatic send_item(input req_type it);
      if (req_gaps && ($urandom_range(99) < 10)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      codec_predict(it);
   endtask

   function automatic req_type make_send(input logic [7:0] cmd, input logic [7:0] d1,
                                         input logic [7:0] d2);
      req_type it;
      it              = '0;
      it.opcode       = OP_SEND;
      it.command_code = cmd;
      it.data_first   = d1;
      it.data_second  = d2;
      it.rx_byte      = 8'($urandom);      // unused fields still toggle
      it.rx_last      = 1'($urandom);
      return it;
   endfunction

   function automatic req_type make_recv(input logic [7:0] b, input logic last);
      req_type it;
      it              = '0;
      it.opcode       = OP_RECV;
      it.command_code = 8'($urandom);
      it.data_first   = 8'($urandom);
      it.data_second  = 8'($urandom);
      it.rx_byte      = b;
      it.rx_last      = last;
      return it;
   endfunction

   // one receive frame, rx_last on its final byte; with mix_sends set, an occasional
   // send is slipped in ahead of a byte
   task automatic send_rx_bytes(input byte_q_t bytes, input bit mix_sends, inout int items);
      for (int i = 0; i < bytes.size(); i++) begin
         if (mix_sends && ($urandom_range(9) == 0)) begin
            send_item(make_send(8'($urandom), 8'($urandom), 8'($urandom)));
            items++;
         end
         send_item(make_recv(bytes[i], i == bytes.size() - 1));
         items++;
      end
   endtask

   // let everything in flight come out, then give the back end time to settle
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both framing registers, one beat each; only called with the block idle
   task automatic program_framing(input logic [7:0] head_v, input logic [7:0] tail_v);
      csr_valid <= 1'b1;
      csr_index <= CSR_HEAD;
      csr_wdata <= head_v;
      do @(posedge clock); while (!csr_ready);
      head_cfg = head_v;
      csr_index <= CSR_END;
      csr_wdata <= tail_v;
      do @(posedge clock); while (!csr_ready);
      tail_cfg = tail_v;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] non_mark_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == START_MARK);
      return b;
   endfunction

   // mostly well-formed frames with random content, the rest broken or noise
   task automatic random_rx_frame(inout int items);
      byte_q_t     bytes;
      int          kind;
      int          pos;
      logic [7:0]  c, d1, d2, first;
      logic [15:0] w;
      kind = $urandom_range(9);
      c    = 8'($urandom);
      d1   = 8'($urandom);
      d2   = 8'($urandom);
      if (kind <= 6) begin
         // kind 5 has no start mark, so the frame is taken from position 0
         first = (kind == 5) ? non_mark_byte() : START_MARK;
         if (kind != 5 && $urandom_range(2) == 0) begin
            bytes.push_back(non_mark_byte());
         end
         w = crc16_wire(first, c, d1, d2);
         bytes.push_back(first);
         bytes.push_back(c);
         bytes.push_back(d1);
         bytes.push_back(d2);
         bytes.push_back(w[15:8]);
         bytes.push_back(w[7:0]);
         if (kind == 6) begin
            pos = $urandom_range(bytes.size() - 1);
            bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(7));
         end
      end else begin
         // overlong or short noise, start marks sprinkled in
         repeat ((kind == 7) ? $urandom_range(7, 10) : $urandom_range(1, 5)) begin
            bytes.push_back(($urandom_range(3) == 0) ? START_MARK : 8'($urandom));
         end
      end
      send_rx_bytes(bytes, 1'b1, items);
   endtask

   task automatic random_traffic(input int n_items);
      int items;
      items = 0;
      while (items < n_items) begin
         if ($urandom_range(3) == 0) begin
            send_item(make_send(8'($urandom), 8'($urandom), 8'($urandom)));
            items++;
         end else begin
            random_rx_frame(items);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   task automatic test_send_extremes();
      send_item(make_send(8'h00, 8'h00, 8'h00));
      send_item(make_send(8'hFF, 8'hFF, 8'hFF));
      send_item(make_send(8'h5A, 8'hA5, 8'h0F));
   endtask

   // clean frame with a send arriving mid-reception
   task automatic test_rx_good_frame();
      logic [15:0] w;
      w = crc16_wire(START_MARK, 8'h3C, 8'h81, 8'h7E);
      send_item(make_recv(START_MARK, 1'b0));
      send_item(make_recv(8'h3C, 1'b0));
      send_item(make_send(8'hC1, 8'hC0, 8'h01));
      send_item(make_recv(8'h81, 1'b0));
      send_item(make_recv(8'h7E, 1'b0));
      send_item(make_recv(w[15:8], 1'b0));
      send_item(make_recv(w[7:0], 1'b1));
   endtask

   // valid crc but no start mark anywhere
   task automatic test_rx_no_mark();
      byte_q_t     bytes;
      int          items;
      logic [15:0] w;
      items = 0;
      w = crc16_wire(8'h01, 8'h10, 8'hF0, 8'h00);
      bytes = '{8'h01, 8'h10, 8'hF0, 8'h00, w[15:8], w[7:0]};
      send_rx_bytes(bytes, 1'b0, items);
   endtask

   // start mark on the final buffer slot, then a dropped mark that closes
   // the frame; the check reads past the buffer
   task automatic test_rx_overflow();
      byte_q_t bytes;
      int      items;
      items = 0;
      bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, START_MARK, START_MARK};
      send_rx_bytes(bytes, 1'b0, items);
   endtask

   task automatic test_rx_single_byte();
      send_item(make_recv(START_MARK, 1'b1));
   endtask

   task automatic test_framing_extremes();
      wait_for_drain();
      program_framing(8'h00, 8'hFF);
      send_item(make_send(8'h00, 8'hFF, 8'h00));
      send_item(make_send(8'hFF, 8'h00, 8'hFF));
      wait_for_drain();
      program_framing(8'hFF, 8'h00);
      send_item(make_send(8'hAA, 8'h55, 8'hAA));
      send_item(make_send(8'h55, 8'hAA, 8'h55));
   endtask

   task automatic test_random_phase(input int n_items, input bit idle_on);
      wait_for_drain();
      program_framing(8'($urandom), 8'($urandom));
      req_gaps = idle_on;
      rsp_gaps = idle_on;
      random_traffic(n_items);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // the response side holds off while sends keep coming, so the queue fills
   // and the block has to stall its input
   task automatic test_backpressure();
      wait_for_drain();
      program_framing(HEAD_RESET, END_RESET);
      req_gaps  = 1'b0;
      hold_left = HOLD_CYCLES;
      repeat (20) send_item(make_send(8'($urandom), 8'($urandom), 8'($urandom)));
      req_gaps = 1'b1;
   endtask

   initial begin
      head_cfg = HEAD_RESET;
      tail_cfg = END_RESET;
      clear_rx_shadow();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_send_extremes();
      test_rx_good_frame();
      test_rx_no_mark();
      test_rx_overflow();
      test_rx_single_byte();
      test_framing_extremes();
      test_random_phase(20, 1'b1);
      test_random_phase(15, 1'b0);
      test_random_phase(15, 1'b1);
      test_backpressure();

      wait_for_drain();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
